[rtl/mfr_pkg.sv]
package mfr_pkg;

    // Field and counter widths
    localparam int COUNT_W     = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_VALUE_W = 11;

    typedef logic [COUNT_W-1:0] count_t;

    // Frame limits
    localparam int     MAX_PDU_BYTES = 253;
    localparam int     MBAP_PREFIX   = 6;
    localparam count_t RTU_MAX_FRAME = count_t'(256);
    localparam count_t RTU_MIN_FRAME = count_t'(4);
    localparam count_t HEADER_BYTES  = count_t'(7);
    localparam count_t CAPACITY_RST  = count_t'(260);

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Transport modes
    localparam logic MODE_TCP = 1'b0;
    localparam logic MODE_RTU = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY = 2'd1;

    // Result status codes
    typedef logic [2:0] status_t;
    localparam status_t ST_NEED_MORE = 3'd0;
    localparam status_t ST_OK        = 3'd1;
    localparam status_t ST_BAD_PROTO = 3'd2;
    localparam status_t ST_BAD_LEN   = 3'd3;
    localparam status_t ST_CRC_ERR   = 3'd4;
    localparam status_t ST_OVERFLOW  = 3'd5;

    // Classified input word
    typedef logic [1:0] cmd_kind_t;
    localparam cmd_kind_t CMD_BYTE = 2'd0;
    localparam cmd_kind_t CMD_GAP  = 2'd1;
    localparam cmd_kind_t CMD_NOP  = 2'd2;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic   mode;
        count_t capacity;
    } cfg_t;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] sat8(input count_t v);
        return (v > count_t'(255)) ? 8'hFF : v[7:0];
    endfunction

endpackage

[rtl/mfr_if.sv]
interface mfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_marker;

    modport source (output valid, output data_byte, output end_marker, input ready);
    modport sink   (input valid, input data_byte, input end_marker, output ready);
endinterface

interface mfr_result_if;
    logic              valid;
    logic              ready;
    mfr_pkg::status_t  status;
    logic [15:0]       trans_id;
    logic [7:0]        unit_address;
    logic [7:0]        fn_code;
    logic [7:0]        pdu_bytes;
    logic [15:0]       frame_crc;
    mfr_pkg::count_t   frame_length;

    modport source (output valid, output status, output trans_id, output unit_address,
                    output fn_code, output pdu_bytes, output frame_crc,
                    output frame_length, input ready);
    modport sink   (input valid, input status, input trans_id, input unit_address,
                    input fn_code, input pdu_bytes, input frame_crc,
                    input frame_length, output ready);
endinterface

interface mfr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mfr_pkg::CFG_INDEX_W-1:0]   index;
    logic [mfr_pkg::CFG_VALUE_W-1:0]   value;

    modport source (output valid, output index, output value, input ready);
    modport sink   (input valid, input index, input value, output ready);
endinterface

[rtl/mfr_front.sv]
module mfr_front (
    input  logic          clk,
    input  logic          rst_n,
    mfr_byte_if.sink      rx,
    input  mfr_pkg::cfg_t cfg,
    output logic          push_valid,
    input  logic          push_ready,
    output mfr_pkg::cmd_t push_cmd
);

    logic          valid_reg;
    mfr_pkg::cmd_t cmd_reg;
    mfr_pkg::cmd_t cmd_next;
    logic          accept;

    assign rx.ready = !valid_reg || push_ready;
    assign accept   = rx.valid && rx.ready;

    // Classify: a gap only matters in RTU mode
    always_comb
    begin
        cmd_next.data = rx.data_byte;
        if (!rx.end_marker)
        begin
            cmd_next.kind = mfr_pkg::CMD_BYTE;
        end
        else if (cfg.mode == mfr_pkg::MODE_RTU)
        begin
            cmd_next.kind = mfr_pkg::CMD_GAP;
        end
        else
        begin
            cmd_next.kind = mfr_pkg::CMD_NOP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign push_valid = valid_reg;
    assign push_cmd   = cmd_reg;

endmodule

[rtl/mfr_queue.sv]
module mfr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  mfr_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop,
    output mfr_pkg::cmd_t pop_cmd
);

    mfr_pkg::cmd_t                 entry_reg [mfr_pkg::QUEUE_DEPTH];
    logic [mfr_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [mfr_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [mfr_pkg::QCNT_W-1:0]    count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = (count_reg != mfr_pkg::QCNT_W'(mfr_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    function automatic logic [mfr_pkg::QPTR_W-1:0] ptr_inc(input logic [mfr_pkg::QPTR_W-1:0] p);
        return (p == mfr_pkg::QPTR_W'(mfr_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mfr_pkg::QCNT_W'(mfr_pkg::QUEUE_DEPTH))
        else $error("queue fill level beyond depth");

endmodule

[rtl/mfr_back.sv]
module mfr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  mfr_pkg::cfg_t cfg,
    input  logic          pop_valid,
    output logic          pop,
    input  mfr_pkg::cmd_t pop_cmd,
    mfr_result_if.source  res
);

    // Frame state
    mfr_pkg::count_t  byte_count_reg;
    mfr_pkg::count_t  byte_count_next;
    mfr_pkg::count_t  expected_length_reg;
    mfr_pkg::count_t  expected_length_next;
    logic [7:0]       head_reg [8];
    logic [7:0]       head_next [8];
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [15:0]      pair_reg;
    logic [15:0]      pair_next;

    // Result register
    logic             out_valid_reg;
    logic [2:0]       out_status_reg;
    logic [15:0]      out_tid_reg;
    logic [7:0]       out_unit_reg;
    logic [7:0]       out_func_reg;
    logic [7:0]       out_size_reg;
    logic [15:0]      out_crc_reg;
    logic [10:0]      out_length_reg;

    // Step results
    mfr_pkg::status_t st;
    logic [15:0]      r_tid;
    logic [7:0]       r_unit;
    logic [7:0]       r_func;
    logic [7:0]       r_size;
    logic [15:0]      r_crc;
    mfr_pkg::count_t  r_length;
    logic             frame_clear;
    logic             byte_update;
    logic [15:0]      recv_crc;
    logic [15:0]      pdu_len;
    logic [16:0]      frame_total;
    logic             take;

    assign take      = pop_valid && (!out_valid_reg || res.ready);
    assign pop       = take;
    assign recv_crc  = {pair_reg[7:0], pair_reg[15:8]};
    assign pair_next = {pair_reg[7:0], pop_cmd.data};
    assign crc_next  = (byte_count_reg >= mfr_pkg::count_t'(2))
                     ? mfr_pkg::crc_feed(crc_reg, pair_reg[15:8]) : crc_reg;
    assign byte_count_next = byte_count_reg + 1'b1;

    // Only the first eight bytes of a frame land in the head
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            head_next[i] = (byte_count_reg[10:3] == '0 && byte_count_reg[2:0] == 3'(i))
                         ? pop_cmd.data : head_reg[i];
        end
    end

    assign pdu_len     = {head_next[4], head_next[5]};
    assign frame_total = 17'(pdu_len) + 17'(mfr_pkg::MBAP_PREFIX);

    always_comb
    begin
        st                   = mfr_pkg::ST_NEED_MORE;
        r_tid                = '0;
        r_unit               = '0;
        r_func               = '0;
        r_size               = '0;
        r_crc                = '0;
        r_length             = '0;
        frame_clear          = 1'b0;
        byte_update          = 1'b0;
        expected_length_next = expected_length_reg;
        unique case (pop_cmd.kind)
            mfr_pkg::CMD_NOP:
            begin
            end
            mfr_pkg::CMD_GAP:
            begin
                if (byte_count_reg < mfr_pkg::RTU_MIN_FRAME)
                begin
                    st = mfr_pkg::ST_NEED_MORE;
                end
                else if (byte_count_reg > mfr_pkg::RTU_MAX_FRAME)
                begin
                    st          = mfr_pkg::ST_BAD_LEN;
                    frame_clear = 1'b1;
                end
                else if (recv_crc != crc_reg)
                begin
                    st          = mfr_pkg::ST_CRC_ERR;
                    frame_clear = 1'b1;
                end
                else
                begin
                    st          = mfr_pkg::ST_OK;
                    r_unit      = head_reg[0];
                    r_func      = head_reg[1];
                    r_size      = mfr_pkg::sat8(byte_count_reg - mfr_pkg::count_t'(4));
                    r_crc       = recv_crc;
                    r_length    = byte_count_reg;
                    frame_clear = 1'b1;
                end
            end
            mfr_pkg::CMD_BYTE:
            begin
                if (byte_count_reg >= cfg.capacity)
                begin
                    st          = mfr_pkg::ST_OVERFLOW;
                    frame_clear = 1'b1;
                end
                else
                begin
                    byte_update = 1'b1;
                    if (cfg.mode == mfr_pkg::MODE_TCP)
                    begin
                        if (expected_length_reg == '0 && byte_count_next >= mfr_pkg::HEADER_BYTES)
                        begin
                            if (head_next[2] != 8'h00 || head_next[3] != 8'h00)
                            begin
                                st          = mfr_pkg::ST_BAD_PROTO;
                                frame_clear = 1'b1;
                            end
                            else if (pdu_len < 16'd2
                                     || pdu_len > 16'(mfr_pkg::MAX_PDU_BYTES + 1))
                            begin
                                st          = mfr_pkg::ST_BAD_LEN;
                                frame_clear = 1'b1;
                            end
                            else if (frame_total > {6'b0, cfg.capacity})
                            begin
                                st          = mfr_pkg::ST_OVERFLOW;
                                frame_clear = 1'b1;
                            end
                            else
                            begin
                                expected_length_next = frame_total[10:0];
                            end
                        end
                        if (!frame_clear && expected_length_next != '0
                            && byte_count_next >= expected_length_next)
                        begin
                            st          = mfr_pkg::ST_OK;
                            r_tid       = {head_next[0], head_next[1]};
                            r_unit      = head_next[6];
                            r_func      = head_next[7];
                            r_size      = mfr_pkg::sat8(expected_length_next
                                                        - mfr_pkg::count_t'(8));
                            r_length    = expected_length_next;
                            frame_clear = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg      <= '0;
            expected_length_reg <= '0;
            crc_reg             <= mfr_pkg::CRC_INIT;
            pair_reg            <= '0;
            for (int i = 0; i < 8; i++)
            begin
                head_reg[i] <= '0;
            end
        end
        else if (take)
        begin
            if (frame_clear)
            begin
                byte_count_reg      <= '0;
                expected_length_reg <= '0;
                crc_reg             <= mfr_pkg::CRC_INIT;
                pair_reg            <= '0;
                for (int i = 0; i < 8; i++)
                begin
                    head_reg[i] <= '0;
                end
            end
            else
            begin
                expected_length_reg <= expected_length_next;
                if (byte_update)
                begin
                    byte_count_reg <= byte_count_next;
                    crc_reg        <= crc_next;
                    pair_reg       <= pair_next;
                    for (int i = 0; i < 8; i++)
                    begin
                        head_reg[i] <= head_next[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_status_reg <= st;
            out_tid_reg    <= r_tid;
            out_unit_reg   <= r_unit;
            out_func_reg   <= r_func;
            out_size_reg   <= r_size;
            out_crc_reg    <= r_crc;
            out_length_reg <= r_length;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.status       = out_status_reg;
    assign res.trans_id     = out_tid_reg;
    assign res.unit_address = out_unit_reg;
    assign res.fn_code      = out_func_reg;
    assign res.pdu_bytes    = out_size_reg;
    assign res.frame_crc    = out_crc_reg;
    assign res.frame_length = out_length_reg;

    a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (take && st != mfr_pkg::ST_NEED_MORE)
        |=> (byte_count_reg == '0 && expected_length_reg == '0 && crc_reg == mfr_pkg::CRC_INIT))
        else $error("frame state not cleared after a verdict");

    a_expected_range: assert property (@(posedge clk) disable iff (!rst_n)
        expected_length_reg == '0
        || (expected_length_reg >= mfr_pkg::count_t'(8)
            && expected_length_reg <= mfr_pkg::count_t'(mfr_pkg::MBAP_PREFIX
                                                       + mfr_pkg::MAX_PDU_BYTES + 1)))
        else $error("expected frame length out of range");

    a_fields_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != mfr_pkg::ST_OK)
        |-> (out_length_reg == '0 && out_tid_reg == '0 && out_crc_reg == '0))
        else $error("result fields set on a non-ok status");

endmodule

[rtl/modbus_frame_receiver_core.sv]
// Modbus frame receiver, TCP (MBAP header) or RTU (CRC-16 and frame gap).
// Channels:
//   rx  - one word per received byte, or a frame gap when end_marker is set.
//   res - one status word for every rx word, in order. Header fields and sizes
//         are filled only when status reports a good frame.
//   cfg - register writes: index 0 transport mode, index 1 buffer capacity.
//         cfg.ready is always high; write only while the block is idle.
// Throughput: one rx word per cycle while res.ready stays high. The per-byte CRC
// step is fully unrolled in the back stage, so the back stage adds no stall of its own.
// Path: the front register loads on the rx accepting edge, then the word moves
// into a queue slot, then into the result register, where res.valid rises.
// Stall: when res.ready stays low the result word holds, the two-entry queue
// and the front register fill, and rx.ready drops after three more words.
// Reset: rst_n clears the frame state and selects TCP with a capacity of 260
// bytes; no word is pending afterward.
module modbus_frame_receiver_core (
    input  logic         clk,
    input  logic         rst_n,
    mfr_byte_if.sink     rx,
    mfr_result_if.source res,
    mfr_cfg_if.sink      cfg
);

    // Configuration registers
    logic            mode_reg;
    mfr_pkg::count_t capacity_reg;
    mfr_pkg::cfg_t   cfg_now;

    // Front to queue, queue to back
    logic            push_valid;
    logic            push_ready;
    mfr_pkg::cmd_t   push_cmd;
    logic            pop_valid;
    logic            pop;
    mfr_pkg::cmd_t   pop_cmd;

    assign cfg.ready = 1'b1;

    // Decode the register index; writes to unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= mfr_pkg::MODE_TCP;
            capacity_reg <= mfr_pkg::CAPACITY_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mfr_pkg::CFG_MODE:     mode_reg     <= cfg.value[0];
                mfr_pkg::CFG_CAPACITY: capacity_reg <= cfg.value;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_now.mode     = mode_reg;
    assign cfg_now.capacity = capacity_reg;

    // Front: accept and classify each rx word
    mfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .cfg        (cfg_now),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Short queue decouples front and back stalls
    mfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_cmd    (pop_cmd)
    );

    // Back: advance the frame state, run the CRC, and register the status word
    mfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_now),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_cmd   (pop_cmd),
        .res       (res)
    );

endmodule
